[rtl/ncf_pkg.sv]
// Package: constants and types for the negative cycle finder.
`default_nettype none
package ncf_pkg;
   localparam int MAX_NODES = 64;
   localparam int MAX_EDGES = 1024;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int PRED_W    = NODE_W + 1;
   localparam int EADDR_W   = $clog2(MAX_EDGES);
   localparam int ECNT_W    = EADDR_W + 1;
   localparam int EDGE_W    = 2 * NODE_W + 16;
   localparam int DIST_W    = 32;
   localparam int NCNT_W    = 7;
   localparam logic [PRED_W-1:0] NONE_MARK = PRED_W'(MAX_NODES);
   localparam logic signed [DIST_W-1:0] DIST_LOW = 32'sh80000001;

   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [PRED_W-1:0]  pred_type;
   typedef logic [EDGE_W-1:0]  edge_type;
   typedef logic signed [DIST_W-1:0] dist_type;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_RUN  = 1'b1;
endpackage
`default_nettype wire

[rtl/ncf_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered read.
`default_nettype none
module ncf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/negative_cycle_finder.sv]
// Top level: edge loading, Bellman-Ford relaxation rounds and cycle extraction.
//
//  port group  | dir | word contents (low bit first)
//  req_*       | in  | tuser: kind; tdata: edge_source, edge_target, edge_weight
//  rsp_*       | out | tdata: found, cycle_node; tlast: final_result
//  csr_*       | in  | csr_data: node_count
//
// A search first clears all MAX_NODES distances and predecessors, then runs node_count
// rounds (node_count clamped to 2..MAX_NODES), each an edge read and a read-modify-write
// on the distance RAM per stored edge.
// The walk takes up to node_count predecessor reads and the gathering up to node_count
// more. Reset is synchronous; stored edges are undefined until loaded. A stalled rsp
// output holds the search and req.
`default_nettype none
module negative_cycle_finder
   import ncf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // edge_source[5:0], edge_target[11:6], edge_weight[27:12]
   input  wire logic        req_tuser,   // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // found[0], cycle_node[6:1]
   output logic             rsp_tlast,   // final_result
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_data     // node_count
);
   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_ERD, S_SRD, S_TRD, S_UPD, S_CHK,
      S_WRD, S_WNX, S_GPUSH, S_GCHK, S_KRD, S_EMIT
   } state_type;

   state_type              state_ff;
   logic [NCNT_W-1:0]      ncfg_ff;
   logic [NCNT_W-1:0]      n_ff;
   logic [ECNT_W-1:0]      ecnt_ff;
   logic [ECNT_W-1:0]      eidx_ff;
   logic [NCNT_W-1:0]      round_ff;
   logic [NCNT_W-1:0]      cnt_ff;
   logic [NODE_W-1:0]      clr_ff;
   pred_type               last_ff;
   node_type               cur_ff;
   node_type               start_ff;
   node_type               s_ff, t_ff;
   logic signed [15:0]     w_ff;
   dist_type               ds_ff;
   logic [NODE_W-1:0]      sp_ff;
   logic                   rv_ff;
   logic [7:0]             rd_ff;
   logic                   rl_ff;

   // edge RAM
   logic                   e_we;
   logic [EADDR_W-1:0]     e_ra;
   edge_type               e_rd;
   // distance RAM
   logic                   d_we;
   node_type               d_wa, d_ra;
   dist_type               d_wd, d_rd;
   // predecessor RAM
   logic                   p_we;
   node_type               p_wa, p_ra;
   pred_type               p_wd, p_rd;
   // node stack
   logic                   k_we;
   node_type               k_wa, k_ra, k_wd, k_rd;

   ncf_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge (
      .clock, .wr_en(e_we), .wr_addr(ecnt_ff[EADDR_W-1:0]),
      .wr_data({req_tdata[5:0], req_tdata[11:6], req_tdata[27:12]}),
      .rd_addr(e_ra), .rd_data(e_rd));
   ncf_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist (
      .clock, .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd), .rd_addr(d_ra), .rd_data(d_rd));
   ncf_ram #(.WIDTH(PRED_W), .DEPTH(MAX_NODES)) u_pred (
      .clock, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd), .rd_addr(p_ra), .rd_data(p_rd));
   ncf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_stack (
      .clock, .wr_en(k_we), .wr_addr(k_wa), .wr_data(k_wd), .rd_addr(k_ra), .rd_data(k_rd));

   logic                   idle;
   logic                   out_free;
   logic                   s_ok, t_ok;
   logic signed [DIST_W:0] sum;
   logic                   relax;
   logic                   relax_ok;
   dist_type               sum_sat;
   logic [NCNT_W-1:0]      ncl;
   logic                   load_out;
   logic                   rv_in;
   logic [7:0]             rd_in;
   logic                   rl_in;

   assign idle       = (state_ff == S_IDLE);
   assign out_free   = !rv_ff || rsp_tready;
   assign req_tready = idle && out_free;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tlast  = rl_ff;
   assign e_we       = req_tready && req_tvalid && (req_tuser == KIND_LOAD)
                       && (ecnt_ff < ECNT_W'(MAX_EDGES));

   assign ncl   = (ncfg_ff < NCNT_W'(2)) ? NCNT_W'(2) :
                  (ncfg_ff > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : ncfg_ff;
   assign s_ok  = {1'b0, s_ff} < n_ff;
   assign t_ok  = {1'b0, t_ff} < n_ff;
   assign sum   = (DIST_W+1)'(ds_ff) + (DIST_W+1)'(w_ff);
   assign relax = sum < (DIST_W+1)'(d_rd);
   assign relax_ok = relax && s_ok && t_ok;
   assign sum_sat = (sum < (DIST_W+1)'(DIST_LOW)) ? DIST_LOW : sum[DIST_W-1:0];
   assign rv_in = load_out || (rv_ff && !rsp_tready);

   always_comb begin
      e_ra = eidx_ff[EADDR_W-1:0];
      d_we = 1'b0; d_wa = t_ff; d_wd = sum_sat; d_ra = t_ff;
      p_we = 1'b0; p_wa = t_ff; p_wd = {1'b0, s_ff}; p_ra = cur_ff;
      k_we = 1'b0; k_wa = cnt_ff[NODE_W-1:0]; k_wd = cur_ff; k_ra = sp_ff;
      load_out = 1'b0; rd_in = '0; rl_in = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            d_we = 1'b1; d_wa = clr_ff; d_wd = '0;
            p_we = 1'b1; p_wa = clr_ff; p_wd = NONE_MARK;
         end
         S_SRD:   d_ra = e_rd[EDGE_W-1 -: NODE_W];
         S_UPD: begin
            d_we = relax_ok;
            p_we = relax_ok;
         end
         S_CHK:   load_out = (round_ff == n_ff) && (last_ff == NONE_MARK) && out_free;
         S_GPUSH: k_we = 1'b1;
         S_EMIT: begin
            load_out = out_free;
            rd_in    = {1'b0, k_rd, 1'b1};
            rl_in    = (sp_ff == '0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ncfg_ff  <= NCNT_W'(MAX_NODES);
         ecnt_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) ncfg_ff <= csr_data;
         if (e_we) ecnt_ff <= ecnt_ff + ECNT_W'(1);
         rv_ff <= rv_in;
         if (load_out) begin
            rd_ff <= rd_in;
            rl_ff <= rl_in;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready && req_tuser == KIND_RUN) begin
                  n_ff     <= ncl;
                  clr_ff   <= '0;
                  state_ff <= S_CLEAR;
               end
            end
            S_CLEAR: begin
               clr_ff <= clr_ff + NODE_W'(1);
               if (clr_ff == NODE_W'(MAX_NODES - 1)) begin
                  round_ff <= '0;
                  eidx_ff  <= '0;
                  last_ff  <= NONE_MARK;
                  state_ff <= S_ERD;
               end
            end
            S_ERD: begin
               if (eidx_ff == ecnt_ff) begin
                  round_ff <= round_ff + NCNT_W'(1);
                  state_ff <= S_CHK;
               end else begin
                  state_ff <= S_SRD;
               end
            end
            S_SRD: begin
               s_ff     <= e_rd[EDGE_W-1 -: NODE_W];
               t_ff     <= e_rd[16 +: NODE_W];
               w_ff     <= e_rd[15:0];
               state_ff <= S_TRD;
            end
            S_TRD: begin
               ds_ff    <= d_rd;
               state_ff <= S_UPD;
            end
            S_UPD: begin
               if (relax_ok) last_ff <= {1'b0, t_ff};
               eidx_ff  <= eidx_ff + ECNT_W'(1);
               state_ff <= S_ERD;
            end
            S_CHK: begin
               if (round_ff != n_ff) begin
                  eidx_ff  <= '0;
                  last_ff  <= NONE_MARK;
                  state_ff <= S_ERD;
               end else if (last_ff == NONE_MARK) begin
                  if (out_free) state_ff <= S_IDLE;
               end else begin
                  cur_ff   <= last_ff[NODE_W-1:0];
                  cnt_ff   <= '0;
                  state_ff <= S_WRD;
               end
            end
            S_WRD: state_ff <= S_WNX;
            S_WNX: begin
               if (p_rd >= n_ff) begin
                  start_ff <= cur_ff;
                  cnt_ff   <= '0;
                  state_ff <= S_GPUSH;
               end else if (cnt_ff + NCNT_W'(1) == n_ff) begin
                  start_ff <= p_rd[NODE_W-1:0];
                  cur_ff   <= p_rd[NODE_W-1:0];
                  cnt_ff   <= '0;
                  state_ff <= S_GPUSH;
               end else begin
                  cur_ff   <= p_rd[NODE_W-1:0];
                  cnt_ff   <= cnt_ff + NCNT_W'(1);
                  state_ff <= S_WRD;
               end
            end
            S_GPUSH: begin
               cnt_ff   <= cnt_ff + NCNT_W'(1);
               state_ff <= S_GCHK;
            end
            S_GCHK: begin
               if (p_rd < n_ff && p_rd[NODE_W-1:0] != start_ff && cnt_ff < n_ff) begin
                  cur_ff   <= p_rd[NODE_W-1:0];
                  state_ff <= S_GPUSH;
               end else begin
                  sp_ff    <= cnt_ff[NODE_W-1:0] - NODE_W'(1);
                  state_ff <= S_KRD;
               end
            end
            S_KRD: state_ff <= S_EMIT;
            S_EMIT: begin
               if (out_free) begin
                  if (sp_ff == '0) begin
                     state_ff <= S_IDLE;
                  end else begin
                     sp_ff    <= sp_ff - NODE_W'(1);
                     state_ff <= S_KRD;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast));
   a_ecnt_max: assert property (@(posedge clock) disable iff (reset)
      ecnt_ff <= ECNT_W'(MAX_EDGES));
   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tlast && rsp_tdata[6:1] == '0);
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7] == 1'b0);
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid || rsp_tready);
endmodule
`default_nettype wire
